@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the report filter rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// combinational property checked at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ hw/rtl/bsrf_pkg.sv @@
// types, codes and constants of the battery soc report filter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bsrf_pkg;

   localparam int unsigned VCELL_W      = 16;
   localparam int unsigned SOC_W        = 8;
   localparam int unsigned PCT_W        = 7;
   localparam int unsigned MV_W         = 16;
   localparam int unsigned CSR_INDEX_W  = 3;
   localparam int unsigned CSR_DATA_W   = 16;
   localparam int unsigned BAD_CNT_W    = 8;
   localparam int unsigned ZERO_CNT_W   = 10;

   // voltage scale 625 / 2048 mV per lsb
   localparam int unsigned VCELL_MUL    = 625;
   localparam int unsigned VCELL_SHIFT  = 11;
   localparam int unsigned VPROD_W      = 26;

   localparam int unsigned PCT_FULL     = 100;
   localparam int unsigned FRAC_MUL     = 100;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRACTION_LOW      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRACTION_HIGH     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BAD_SOC_LIMIT     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_CHARGE_LIMIT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ABSENT_VOLTAGE    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SERIES_DOUBLE     = 3'd5;

   localparam logic [PCT_W-1:0]      RST_FRACTION_LOW      = 7'd30;
   localparam logic [PCT_W-1:0]      RST_FRACTION_HIGH     = 7'd70;
   localparam logic [BAD_CNT_W-1:0]  RST_BAD_SOC_LIMIT     = 8'd5;
   localparam logic [ZERO_CNT_W-1:0] RST_ZERO_CHARGE_LIMIT = 10'd225;
   localparam logic [MV_W-1:0]       RST_ABSENT_VOLTAGE    = 16'd3700;

   localparam logic [1:0] STATUS_UNKNOWN     = 2'd0;
   localparam logic [1:0] STATUS_CHARGING    = 2'd1;
   localparam logic [1:0] STATUS_DISCHARGING = 2'd2;
   localparam logic [1:0] STATUS_FULL        = 2'd3;

   localparam logic [1:0] CAUSE_NONE        = 2'd0;
   localparam logic [1:0] CAUSE_ASLEEP      = 2'd1;
   localparam logic [1:0] CAUSE_SOC_RANGE   = 2'd2;
   localparam logic [1:0] CAUSE_ZERO_CHARGE = 2'd3;

   typedef struct packed {
      logic [VCELL_W-1:0] vcell_first;
      logic [VCELL_W-1:0] vcell_second;
      logic [VCELL_W-1:0] vcell_third;
      logic [SOC_W-1:0]   soc_whole;
      logic [SOC_W-1:0]   soc_fraction;
      logic               charger_online;
      logic               gauge_reachable;
      logic               gauge_asleep;
   } req_item_type;

   typedef struct packed {
      logic [PCT_W-1:0] capacity_pct;
      logic [MV_W-1:0]  voltage_mv;
      logic [1:0]       charge_status;
      logic             charging;
      logic             changed;
      logic [1:0]       restart_cause;
   } rsp_item_type;

   typedef struct packed {
      logic                   wr_en;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  wdata;
   } csr_write_type;

endpackage

`default_nettype wire

@@ hw/rtl/bsrf_in_stage.sv @@
// input register of the report filter, one transaction deep
// depends on bsrf_pkg
`timescale 1ns / 1ps
`default_nettype none

module bsrf_in_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire bsrf_pkg::req_item_type req_item,
   output logic                       req_stall,
   input  wire logic                  drain_ready,
   output logic                       item_valid,
   output bsrf_pkg::req_item_type     item,
   output logic                       advance
);
   import bsrf_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;
   logic         load;

   assign advance   = valid_ff && drain_ready;
   assign req_stall = valid_ff && !drain_ready;
   assign load      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in = 1'b1;
         item_in  = req_item;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

@@ hw/rtl/bsrf_core.sv @@
// filter state, configuration registers and per-tick update logic
// depends on bsrf_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bsrf_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire bsrf_pkg::csr_write_type csr,
   input  wire logic                   step,
   input  wire bsrf_pkg::req_item_type item,
   output bsrf_pkg::rsp_item_type      result
);
   import bsrf_pkg::*;

   // configuration
   logic [PCT_W-1:0]      frac_low_ff, frac_high_ff;
   logic [BAD_CNT_W-1:0]  bad_limit_ff;
   logic [ZERO_CNT_W-1:0] zero_limit_ff;
   logic [MV_W-1:0]       absent_mv_ff;
   logic                  series_ff;

   // held report
   logic [PCT_W-1:0]      cap_ff, cap_in;
   logic [MV_W-1:0]       volt_ff, volt_in;
   logic                  chg_ff, chg_in;
   logic [1:0]            status_ff, status_in;
   logic [BAD_CNT_W-1:0]  bad_cnt_ff, bad_cnt_in;
   logic [ZERO_CNT_W-1:0] zero_cnt_ff, zero_cnt_in;

   logic [VCELL_W-1:0]    lo, hi, mid_hi, med;
   logic [VPROD_W-1:0]    vprod;
   logic [MV_W-2:0]       mv_single;
   logic [MV_W-1:0]       mv;
   logic [SOC_W+PCT_W-1:0] fprod;
   logic [PCT_W-1:0]      rem;
   logic [BAD_CNT_W-1:0]  bad_inc;
   logic [ZERO_CNT_W-1:0] zero_inc;
   logic [SOC_W-1:0]      ui;
   logic                  outside, near;
   logic                  changed;
   logic [1:0]            cause;

   always_ff @(posedge clock) begin
      if (reset) begin
         frac_low_ff   <= RST_FRACTION_LOW;
         frac_high_ff  <= RST_FRACTION_HIGH;
         bad_limit_ff  <= RST_BAD_SOC_LIMIT;
         zero_limit_ff <= RST_ZERO_CHARGE_LIMIT;
         absent_mv_ff  <= RST_ABSENT_VOLTAGE;
         series_ff     <= 1'b0;
      end else if (csr.wr_en) begin
         case (csr.index)
            CSR_FRACTION_LOW:      frac_low_ff   <= csr.wdata[PCT_W-1:0];
            CSR_FRACTION_HIGH:     frac_high_ff  <= csr.wdata[PCT_W-1:0];
            CSR_BAD_SOC_LIMIT:     bad_limit_ff  <= csr.wdata[BAD_CNT_W-1:0];
            CSR_ZERO_CHARGE_LIMIT: zero_limit_ff <= csr.wdata[ZERO_CNT_W-1:0];
            CSR_ABSENT_VOLTAGE:    absent_mv_ff  <= csr.wdata[MV_W-1:0];
            CSR_SERIES_DOUBLE:     series_ff     <= csr.wdata[0];
            default: ;
         endcase
      end
   end

   // median of three and scaling
   always_comb begin
      lo     = (item.vcell_first > item.vcell_second) ? item.vcell_second : item.vcell_first;
      hi     = (item.vcell_first > item.vcell_second) ? item.vcell_first : item.vcell_second;
      mid_hi = (hi > item.vcell_third) ? item.vcell_third : hi;
      med    = (lo > mid_hi) ? lo : mid_hi;
      vprod  = {{(VPROD_W-VCELL_W){1'b0}}, med} * VPROD_W'(VCELL_MUL);
      mv_single = vprod[VCELL_SHIFT +: (MV_W-1)];
      mv     = series_ff ? {mv_single, 1'b0} : {1'b0, mv_single};
      fprod  = {{PCT_W{1'b0}}, item.soc_fraction} * (SOC_W+PCT_W)'(FRAC_MUL);
      rem    = fprod[SOC_W +: PCT_W];
      bad_inc  = (bad_cnt_ff != '1) ? bad_cnt_ff + 1'b1 : bad_cnt_ff;
      zero_inc = (zero_cnt_ff != '1) ? zero_cnt_ff + 1'b1 : zero_cnt_ff;
   end

   always_comb begin
      cap_in      = cap_ff;
      volt_in     = volt_ff;
      chg_in      = chg_ff;
      status_in   = status_ff;
      bad_cnt_in  = bad_cnt_ff;
      zero_cnt_in = zero_cnt_ff;
      changed     = 1'b0;
      cause       = CAUSE_NONE;
      ui          = item.soc_whole;
      outside     = 1'b0;
      near        = 1'b0;
      if (!item.gauge_reachable) begin
         cap_in  = '0;
         volt_in = absent_mv_ff;
         changed = 1'b1;
      end else begin
         if (item.gauge_asleep) begin
            cause = CAUSE_ASLEEP;
         end
         if (mv != volt_ff) begin
            volt_in = mv;
            changed = 1'b1;
         end
         chg_in = item.charger_online;
         if (item.charger_online != chg_ff) begin
            changed = 1'b1;
         end
         if (item.soc_whole > SOC_W'(PCT_FULL)) begin
            bad_cnt_in = bad_inc;
            if (bad_inc > bad_limit_ff) begin
               cause      = CAUSE_SOC_RANGE;
               bad_cnt_in = '0;
            end
         end else begin
            bad_cnt_in = '0;
            if (chg_in && item.soc_whole == '0) begin
               zero_cnt_in = zero_inc;
               if (zero_inc > zero_limit_ff) begin
                  cause       = CAUSE_ZERO_CHARGE;
                  zero_cnt_in = '0;
               end
            end else begin
               zero_cnt_in = '0;
            end
            outside = (rem > frac_high_ff) || (rem < frac_low_ff);
            near    = ({1'b0, item.soc_whole} + 9'd1 >= {2'b00, cap_ff}) &&
                      ({1'b0, item.soc_whole} <= {2'b00, cap_ff} + 9'd1);
            if (item.soc_whole < SOC_W'(PCT_FULL) && outside && near) begin
               ui = {1'b0, cap_ff};
            end
            if (ui != {1'b0, cap_ff}) begin
               if (ui > {1'b0, cap_ff}) begin
                  if (chg_in) begin
                     cap_in = ui[PCT_W-1:0];
                  end
               end else begin
                  cap_in = ui[PCT_W-1:0];
               end
               changed = 1'b1;
            end
         end
         if (chg_in) begin
            status_in = (cap_in >= PCT_W'(PCT_FULL)) ? STATUS_FULL : STATUS_CHARGING;
         end else begin
            status_in = STATUS_DISCHARGING;
         end
         if (status_in != status_ff) begin
            changed = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff      <= '0;
         volt_ff     <= '0;
         chg_ff      <= 1'b0;
         status_ff   <= STATUS_UNKNOWN;
         bad_cnt_ff  <= '0;
         zero_cnt_ff <= '0;
      end else if (step) begin
         cap_ff      <= cap_in;
         volt_ff     <= volt_in;
         chg_ff      <= chg_in;
         status_ff   <= status_in;
         bad_cnt_ff  <= bad_cnt_in;
         zero_cnt_ff <= zero_cnt_in;
      end
   end

   always_comb begin
      result.capacity_pct  = cap_in;
      result.voltage_mv    = volt_in;
      result.charge_status = status_in;
      result.charging      = chg_in;
      result.changed       = changed;
      result.restart_cause = cause;
   end

   `ASSERT_ALWAYS(a_cap_range, clock, reset, cap_ff <= PCT_W'(PCT_FULL))
   `ASSERT_NEXT(a_absent_forces, clock, reset, step && !item.gauge_reachable, cap_ff == '0 && volt_ff == $past(absent_mv_ff))
   `ASSERT_NEXT(a_bad_cause_clears, clock, reset, step && cause == CAUSE_SOC_RANGE, bad_cnt_ff == '0)

endmodule

`default_nettype wire

@@ hw/rtl/bsrf_out_stage.sv @@
// result register of the report filter
// depends on bsrf_pkg
`timescale 1ns / 1ps
`default_nettype none

module bsrf_out_stage (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   load,
   input  wire bsrf_pkg::rsp_item_type result,
   output logic                        ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output bsrf_pkg::rsp_item_type      rsp_item
);
   import bsrf_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff, item_in;

   assign ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in = 1'b1;
         item_in  = result;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

`default_nettype wire

@@ hw/rtl/battery_soc_report_filter_top.sv @@
// top level of the battery soc report filter
// depends on bsrf_pkg, bsrf_in_stage, bsrf_core, bsrf_out_stage, assert_macros.svh
//
//   channel | direction | handshake              | payload
//   req_    | in        | req_valid / req_stall  | three vcell words, soc bytes, flags
//   rsp_    | out       | rsp_valid / rsp_stall  | capacity, voltage, status, flags, cause
//   csr_    | in        | csr_wr_en              | csr_index, csr_wdata
//
// one transaction per cycle sustained while rsp_stall is low; each transaction
// passes the input register, then the result register, where it raises rsp_valid
// the held report updates as a transaction moves from the input to the result register
// a stalled result holds one more transaction in the input register before req_stall rises
// synchronous reset clears valids, held report and counters; configuration returns to defaults
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module battery_soc_report_filter_top (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [bsrf_pkg::VCELL_W-1:0]          req_vcell_first,
   input  wire logic [bsrf_pkg::VCELL_W-1:0]          req_vcell_second,
   input  wire logic [bsrf_pkg::VCELL_W-1:0]          req_vcell_third,
   input  wire logic [bsrf_pkg::SOC_W-1:0]            req_soc_whole,
   input  wire logic [bsrf_pkg::SOC_W-1:0]            req_soc_fraction,
   input  wire logic                                  req_charger_online,
   input  wire logic                                  req_gauge_reachable,
   input  wire logic                                  req_gauge_asleep,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [bsrf_pkg::PCT_W-1:0]                 rsp_capacity_pct,
   output logic [bsrf_pkg::MV_W-1:0]                  rsp_voltage_mv,
   output logic [1:0]                                 rsp_charge_status,
   output logic                                       rsp_charging,
   output logic                                       rsp_changed,
   output logic [1:0]                                 rsp_restart_cause,
   input  wire logic                                  csr_wr_en,
   input  wire logic [bsrf_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [bsrf_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import bsrf_pkg::*;

   req_item_type  req_item, stage_item;
   rsp_item_type  core_result, rsp_item;
   csr_write_type csr;
   logic          stage_valid, advance, drain_ready;

   always_comb begin
      req_item.vcell_first     = req_vcell_first;
      req_item.vcell_second    = req_vcell_second;
      req_item.vcell_third     = req_vcell_third;
      req_item.soc_whole       = req_soc_whole;
      req_item.soc_fraction    = req_soc_fraction;
      req_item.charger_online  = req_charger_online;
      req_item.gauge_reachable = req_gauge_reachable;
      req_item.gauge_asleep    = req_gauge_asleep;
      csr.wr_en = csr_wr_en;
      csr.index = csr_index;
      csr.wdata = csr_wdata;
   end

   bsrf_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_item    (req_item),
      .req_stall   (req_stall),
      .drain_ready (drain_ready),
      .item_valid  (stage_valid),
      .item        (stage_item),
      .advance     (advance)
   );

   bsrf_core u_core (
      .clock  (clock),
      .reset  (reset),
      .csr    (csr),
      .step   (advance),
      .item   (stage_item),
      .result (core_result)
   );

   bsrf_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .result    (core_result),
      .ready     (drain_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   assign rsp_capacity_pct  = rsp_item.capacity_pct;
   assign rsp_voltage_mv    = rsp_item.voltage_mv;
   assign rsp_charge_status = rsp_item.charge_status;
   assign rsp_charging      = rsp_item.charging;
   assign rsp_changed       = rsp_item.changed;
   assign rsp_restart_cause = rsp_item.restart_cause;

   `ASSERT_IMPLIES(a_stall_needs_full, clock, reset, req_stall, stage_valid && rsp_valid && rsp_stall)
   `ASSERT_IMPLIES(a_full_means_charging, clock, reset, rsp_valid && rsp_charge_status == STATUS_FULL, rsp_charging)
   `ASSERT_IMPLIES(a_discharge_flag, clock, reset, rsp_valid && rsp_charge_status == STATUS_DISCHARGING, !rsp_charging)

endmodule

`default_nettype wire
